>>> sv/fpda_pkg.sv
// ----------------------------------------------------------------------------
// fpda_pkg
// shared types and constants for the binary to decimal text converter
// ----------------------------------------------------------------------------
package fpda_pkg;

    localparam int VALUE_W   = 16;
    localparam int BCD_A_W   = 20;
    localparam int BCD_B_W   = 16;
    localparam int STEPS     = 16;
    localparam int MAX_CHARS = 8;
    localparam int FRAC_W    = 14;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_Q4_11    = 1'b1;

    localparam logic [FRAC_W-1:0] FRAC_SCALE = 14'd10000;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // one slot of the conversion chain, two independent lanes
    typedef struct packed {
        logic               valid;
        logic               opcode;
        logic               neg;
        logic [VALUE_W-1:0] bin_a;
        logic [BCD_A_W-1:0] bcd_a;
        logic [VALUE_W-1:0] bin_b;
        logic [BCD_B_W-1:0] bcd_b;
    } dd_t;

endpackage

>>> sv/fpda_cell.sv
// ----------------------------------------------------------------------------
// fpda_cell
// one shift-and-add-3 step on both lanes, registered
// ----------------------------------------------------------------------------
module fpda_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  fpda_pkg::dd_t  d_in,
    output fpda_pkg::dd_t  d_out
);

    function automatic logic [fpda_pkg::BCD_A_W-1:0] adjust(
        input logic [fpda_pkg::BCD_A_W-1:0] bcd
    );
        logic [fpda_pkg::BCD_A_W-1:0] r;
        r = bcd;
        for (int i = 0; i < fpda_pkg::BCD_A_W / 4; i++)
        begin
            if (r[i*4 +: 4] >= 4'd5)
            begin
                r[i*4 +: 4] = r[i*4 +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    logic                          valid_reg;
    fpda_pkg::dd_t                 data_reg;
    fpda_pkg::dd_t                 data_next;
    logic [fpda_pkg::BCD_A_W-1:0]  adj_a;
    logic [fpda_pkg::BCD_A_W-1:0]  adj_b;

    always_comb
    begin
        adj_a = adjust(d_in.bcd_a);
        adj_b = adjust({{(fpda_pkg::BCD_A_W - fpda_pkg::BCD_B_W){1'b0}}, d_in.bcd_b});
        data_next        = d_in;
        data_next.bcd_a  = {adj_a[fpda_pkg::BCD_A_W-2:0], d_in.bin_a[fpda_pkg::VALUE_W-1]};
        data_next.bin_a  = {d_in.bin_a[fpda_pkg::VALUE_W-2:0], 1'b0};
        data_next.bcd_b  = {adj_b[fpda_pkg::BCD_B_W-2:0], d_in.bin_b[fpda_pkg::VALUE_W-1]};
        data_next.bin_b  = {d_in.bin_b[fpda_pkg::VALUE_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        d_out       = data_reg;
        d_out.valid = valid_reg;
    end

endmodule

>>> sv/fpda_serial.sv
// ----------------------------------------------------------------------------
// fpda_serial
// builds the text from the decimal digits and shifts it out a char a cycle
// ----------------------------------------------------------------------------
module fpda_serial (
    input  logic           clk,
    input  logic           rst_n,
    input  fpda_pkg::dd_t  d_in,
    output logic           load_ok,
    output logic           strobe,
    output logic [7:0]     char_code,
    output logic           last_char
);

    localparam int TEXT_W = fpda_pkg::MAX_CHARS * 8;

    logic [TEXT_W-1:0] text_reg;
    logic [TEXT_W-1:0] text_next;
    logic [3:0]        remain_reg;
    logic [3:0]        remain_next;

    logic [7:0]        ca [5];
    logic [7:0]        cf [4];
    logic [TEXT_W-1:0] body;
    logic [TEXT_W-1:0] aligned;
    logic [3:0]        n_body;
    logic [2:0]        pad;
    logic [TEXT_W-1:0] fmt_text;
    logic [3:0]        fmt_len;
    logic              load;

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            ca[i] = fpda_pkg::CHAR_ZERO | {4'b0, d_in.bcd_a[i*4 +: 4]};
        end
        for (int i = 0; i < 4; i++)
        begin
            cf[i] = fpda_pkg::CHAR_ZERO | {4'b0, d_in.bcd_b[i*4 +: 4]};
        end

        if (d_in.opcode == fpda_pkg::OP_Q4_11)
        begin
            body   = {8'b0, ca[1], ca[0], fpda_pkg::CHAR_DOT, cf[3], cf[2], cf[1], cf[0]};
            n_body = (d_in.bcd_a[7:4] != 4'd0) ? 4'd7 : 4'd6;
        end
        else
        begin
            body = {24'b0, ca[4], ca[3], ca[2], ca[1], ca[0]};
            if (d_in.bcd_a[19:16] != 4'd0)
                n_body = 4'd5;
            else if (d_in.bcd_a[15:12] != 4'd0)
                n_body = 4'd4;
            else if (d_in.bcd_a[11:8] != 4'd0)
                n_body = 4'd3;
            else if (d_in.bcd_a[7:4] != 4'd0)
                n_body = 4'd2;
            else
                n_body = 4'd1;
        end

        // left align so the first char sits in the top byte
        pad     = 3'(4'd8 - n_body);
        aligned = body << {pad, 3'b000};

        if (d_in.opcode == fpda_pkg::OP_Q4_11 && d_in.neg)
        begin
            fmt_text = {fpda_pkg::CHAR_MINUS, aligned[TEXT_W-1:8]};
            fmt_len  = n_body + 4'd1;
        end
        else
        begin
            fmt_text = aligned;
            fmt_len  = n_body;
        end
    end

    assign load_ok = (remain_reg <= 4'd1);
    assign load    = d_in.valid && load_ok;

    always_comb
    begin
        text_next   = text_reg;
        remain_next = remain_reg;
        if (load)
        begin
            text_next   = fmt_text;
            remain_next = fmt_len;
        end
        else if (remain_reg != 4'd0)
        begin
            text_next   = {text_reg[TEXT_W-9:0], 8'b0};
            remain_next = remain_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= 4'd0;
        end
        else
        begin
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        text_reg <= text_next;
    end

    assign strobe    = (remain_reg != 4'd0);
    assign char_code = text_reg[TEXT_W-1 -: 8];
    assign last_char = (remain_reg == 4'd1);

endmodule

>>> sv/fixed_point_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_ascii_top
// binary or signed Q4.11 value to decimal ASCII text, one char per strobe
// ----------------------------------------------------------------------------
// usage
//   input transaction: drive opcode and value with start high; it is taken at
//   a rising edge where busy is low. opcode 0 prints value as unsigned
//   decimal, opcode 1 prints it as signed Q4.11 with four fraction digits
//   output: each char is on char_code for exactly one cycle with strobe
//   high; last_char marks the final char of a transaction's text
//   path: the accepting edge loads the prep register; the transaction then
//   passes through sixteen conversion cells and into the text register,
//   whose top byte is the first char
//   throughput: one char per cycle on the output, with 1 to 8 chars in a
//   transaction's text; new transactions are taken every cycle while the
//   chain has room and up to 18 may be in flight (17 in the chain, one in
//   the text register)
//   busy rises only when a finished text waits at the end of the chain for
//   the text register, which stalls the whole chain for that cycle
//   the receiver cannot stall: every strobe is a delivered char
//   reset clears all valid bits and the char counter; nothing else is reset
// ----------------------------------------------------------------------------
module fixed_point_to_decimal_ascii_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [15:0] value,
    output logic        strobe,
    output logic [7:0]  char_code,
    output logic        last_char
);

    fpda_pkg::dd_t stage [fpda_pkg::STEPS + 1];

    logic                             advance;
    logic                             load_ok;
    logic                             accept;
    logic                             prep_valid_reg;
    fpda_pkg::dd_t                    prep_reg;
    fpda_pkg::dd_t                    prep_next;
    logic                             neg;
    logic [16:0]                      mag;
    logic [24:0]                      frac_prod;

    // chain moves unless a finished text has nowhere to go
    assign advance = !(stage[fpda_pkg::STEPS].valid && !load_ok);
    assign busy    = !advance;
    assign accept  = start && !busy;

    // prep: magnitude, integer part and scaled fraction for Q4.11; unsigned values pass as is
    always_comb
    begin
        neg       = (opcode == fpda_pkg::OP_Q4_11) && value[15];
        mag       = neg ? (17'h10000 - {1'b0, value}) : {1'b0, value};
        frac_prod = {3'b0, mag[10:0]} * {11'b0, fpda_pkg::FRAC_SCALE};

        prep_next        = '0;
        prep_next.valid  = accept;
        prep_next.opcode = opcode;
        prep_next.neg    = neg;
        if (opcode == fpda_pkg::OP_Q4_11)
        begin
            prep_next.bin_a = {10'b0, mag[16:11]};
            prep_next.bin_b = {2'b0, frac_prod[24:11]};
        end
        else
        begin
            prep_next.bin_a = value;
            prep_next.bin_b = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            prep_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prep_reg <= prep_next;
        end
    end

    always_comb
    begin
        stage[0]       = prep_reg;
        stage[0].valid = prep_valid_reg;
    end

    // one double dabble step per cell, both lanes in lockstep
    for (genvar g = 0; g < fpda_pkg::STEPS; g++)
    begin : g_cell
        fpda_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .d_in    (stage[g]),
            .d_out   (stage[g+1])
        );
    end

    fpda_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .d_in      (stage[fpda_pkg::STEPS]),
        .load_ok   (load_ok),
        .strobe    (strobe),
        .char_code (char_code),
        .last_char (last_char)
    );

`ifndef NO_ASSERTIONS
    // an accepted transaction lands in the prep register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> prep_valid_reg)
        else $error("accepted transaction lost at prep stage");

    // stall only while a text is still being shifted out
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (stage[fpda_pkg::STEPS].valid && strobe && !last_char))
        else $error("busy without a waiting text");

    // a text never breaks off before its last char
    a_text_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_char) |=> strobe)
        else $error("text ended without last_char");

    // a stalled chain end holds its data
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(stage[fpda_pkg::STEPS]))
        else $error("chain end changed while stalled");
`endif

endmodule
